FILE: design/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared constants and types of the 5x5 RGB median filter.
// ----------------------------------------------------------------------------
package rmf_pkg;

   localparam int MAX_LINE   = 1024;
   localparam int WINDOW     = 5;
   localparam int HALF_WIN   = WINDOW / 2;
   localparam int WIN_CELLS  = WINDOW * WINDOW;
   localparam int MEDIAN_IDX = WIN_CELLS / 2;
   localparam int LINE_AW    = $clog2(MAX_LINE);
   localparam int RANK_W     = $clog2(WIN_CELLS);
   localparam int PIX_W      = 24;
   localparam int LINES      = WINDOW - 1;

   localparam int LEN_W      = 11;
   localparam int CNT_W      = 13;
   localparam int MAX_COLS   = 4096;
   localparam int COL_W      = 13;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLUMN_LENGTH = 2'd0,
      CSR_COLUMN_COUNT  = 2'd1
   } csr_index_type;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [7:0]       sample_type;

endpackage

FILE: design/rmf_req_if.sv
// ----------------------------------------------------------------------------
// rmf_req_if
// Input pixel channel: valid/ready handshake with RGB pixel and flush flag.
// ----------------------------------------------------------------------------
interface rmf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       flush;

   modport source (output valid, red, green, blue, flush, input ready);
   modport sink   (input valid, red, green, blue, flush, output ready);
endinterface

FILE: design/rmf_rsp_if.sv
// ----------------------------------------------------------------------------
// rmf_rsp_if
// Result channel: valid/ready handshake with channel medians and frame end.
// ----------------------------------------------------------------------------
interface rmf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] median_red;
   logic [7:0] median_green;
   logic [7:0] median_blue;
   logic       frame_end;

   modport source (output valid, median_red, median_green, median_blue, frame_end,
                   input ready);
   modport sink   (input valid, median_red, median_green, median_blue, frame_end,
                   output ready);
endinterface

FILE: design/rgb_median_filter_5x5_top.sv
// ----------------------------------------------------------------------------
// rgb_median_filter_5x5_top
// 5x5 per-channel median filter over an RGB pixel stream scanned by column.
//
// Usage:
//   req_bus takes one pixel transaction per clock; pixels arrive column by
//   column, column_length pixels per column, column_count columns. After the
//   last pixel the source sends flush transactions until frame_end is seen.
//   rsp_bus gives one median transaction per pixel position; frame_end marks
//   the last one. The first 2*column_length+2 transactions of a frame give no
//   result. A result passes s1 to s4 and then the response register.
//   Throughput is one transaction per clock unless rsp_bus stalls, set by the
//   single line-store memory, read and written once per transaction.
//   csr_we writes column_length (index 0) or column_count (index 1) and
//   restarts the frame; write only while the block is idle.
//   Reset restores 480 x 640 and restarts the frame; line-store contents are
//   left as they are. When rsp_bus stalls with a result held, the whole
//   pipeline and req_bus.ready hold until the result is taken.
// ----------------------------------------------------------------------------
module rgb_median_filter_5x5_top
   import rmf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   rmf_req_if.sink              req_bus,
   rmf_rsp_if.source            rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata
);

   logic [LEN_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]   cols_ff, cols_in;
   logic [LINE_AW-1:0] scan_row_ff, scan_row_in;
   logic [COL_W-1:0]   scan_col_ff, scan_col_in;
   logic [LINE_AW-1:0] out_row_ff, out_row_in;
   logic [COL_W-1:0]   out_col_ff, out_col_in;

   logic advance, accept, emit, last;
   logic [WINDOW-1:0] rmask, cmask;

   logic [PIX_W*LINES-1:0] mem [MAX_LINE];
   logic [PIX_W*LINES-1:0] rd_ff;

   logic               s1_valid_ff;
   logic               s1_emit_ff;
   logic               s1_last_ff;
   logic [LINE_AW-1:0] s1_row_ff;
   pixel_type          s1_pix_ff;
   logic [WINDOW-1:0]  s1_rmask_ff, s1_cmask_ff;

   pixel_type win_ff [WINDOW][WINDOW];
   pixel_type win_in [WINDOW][WINDOW];
   pixel_type mwin_in [WIN_CELLS];
   pixel_type mwin_ff [WIN_CELLS];
   logic      s2_valid_ff, s2_last_ff;
   logic      s3_valid_ff, s3_last_ff;
   logic      s4_valid_ff, s4_last_ff;
   logic      rsp_valid_ff, rsp_last_ff;

   sample_type chan_samples [3][WIN_CELLS];
   sample_type chan_median  [3];

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign accept        = req_bus.valid && advance;

   // configuration
   always_comb begin
      len_in  = len_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_COLUMN_LENGTH: begin
               if (csr_wdata[LEN_W-1:0] < LEN_W'(WINDOW)) len_in = LEN_W'(WINDOW);
               else if (csr_wdata[LEN_W-1:0] > LEN_W'(MAX_LINE)) len_in = LEN_W'(MAX_LINE);
               else len_in = csr_wdata[LEN_W-1:0];
            end
            CSR_COLUMN_COUNT: begin
               if (csr_wdata < CNT_W'(WINDOW)) cols_in = CNT_W'(WINDOW);
               else if (csr_wdata > CNT_W'(MAX_COLS)) cols_in = CNT_W'(MAX_COLS);
               else cols_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // scan and output position
   always_comb begin
      emit = (scan_col_ff > COL_W'(HALF_WIN)) ||
             ((scan_col_ff == COL_W'(HALF_WIN)) && (scan_row_ff >= LINE_AW'(HALF_WIN)));
      last = emit && ({1'b0, out_row_ff} == len_ff - LEN_W'(1)) &&
             (out_col_ff == COL_W'(cols_ff - CNT_W'(1)));
      for (int d = 0; d < WINDOW; d++) begin
         rmask[d] = ((LEN_W'(out_row_ff) + LEN_W'(d)) >= LEN_W'(HALF_WIN)) &&
                    ((LEN_W'(out_row_ff) + LEN_W'(d)) < len_ff + LEN_W'(HALF_WIN));
         cmask[d] = ((CNT_W'(out_col_ff) + CNT_W'(d)) >= CNT_W'(HALF_WIN)) &&
                    ((CNT_W'(out_col_ff) + CNT_W'(d)) < cols_ff + CNT_W'(HALF_WIN));
      end
      scan_row_in = scan_row_ff;
      scan_col_in = scan_col_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      priority if (csr_we && (csr_index == CSR_COLUMN_LENGTH ||
                              csr_index == CSR_COLUMN_COUNT)) begin
         scan_row_in = '0;
         scan_col_in = '0;
         out_row_in  = '0;
         out_col_in  = '0;
      end else if (accept && last) begin
         scan_row_in = '0;
         scan_col_in = '0;
         out_row_in  = '0;
         out_col_in  = '0;
      end else if (accept) begin
         if ({1'b0, scan_row_ff} == len_ff - LEN_W'(1)) begin
            scan_row_in = '0;
            scan_col_in = scan_col_ff + COL_W'(1);
         end else begin
            scan_row_in = scan_row_ff + LINE_AW'(1);
         end
         if (emit) begin
            if ({1'b0, out_row_ff} == len_ff - LEN_W'(1)) begin
               out_row_in = '0;
               out_col_in = out_col_ff + COL_W'(1);
            end else begin
               out_row_in = out_row_ff + LINE_AW'(1);
            end
         end
      end else begin
         scan_row_in = scan_row_ff;
         scan_col_in = scan_col_ff;
         out_row_in  = out_row_ff;
         out_col_in  = out_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= LEN_W'(480);
         cols_ff     <= CNT_W'(640);
         scan_row_ff <= '0;
         scan_col_ff <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
      end else begin
         len_ff      <= len_in;
         cols_ff     <= cols_in;
         scan_row_ff <= scan_row_in;
         scan_col_ff <= scan_col_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
      end
   end

   // line store: entry holds the pixels one to four columns back
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[scan_row_ff];
      end
      if (advance && s1_valid_ff) begin
         mem[s1_row_ff] <= {rd_ff[PIX_W*(LINES-1)-1:0], s1_pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_row_ff   <= scan_row_ff;
         s1_pix_ff   <= req_bus.flush ? '0 : {req_bus.blue, req_bus.green, req_bus.red};
         s1_emit_ff  <= emit;
         s1_last_ff  <= last;
         s1_rmask_ff <= rmask;
         s1_cmask_ff <= cmask;
      end
   end

   // window shift and edge masking
   always_comb begin
      for (int r = 0; r < WINDOW - 1; r++) begin
         win_in[r] = win_ff[r+1];
      end
      win_in[WINDOW-1][WINDOW-1] = s1_pix_ff;
      for (int c = 0; c < LINES; c++) begin
         win_in[WINDOW-1][LINES-1-c] = rd_ff[PIX_W*c +: PIX_W];
      end
      for (int r = 0; r < WINDOW; r++) begin
         for (int c = 0; c < WINDOW; c++) begin
            mwin_in[r*WINDOW+c] = (s1_rmask_ff[r] && s1_cmask_ff[c]) ? win_in[r][c] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         win_ff <= win_in;
      end
      if (advance) begin
         mwin_ff     <= mwin_in;
         s2_last_ff  <= s1_last_ff;
         s3_last_ff  <= s2_last_ff;
         s4_last_ff  <= s3_last_ff;
         rsp_last_ff <= s4_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff && s1_emit_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int i = 0; i < WIN_CELLS; i++) begin
            chan_samples[ch][i] = mwin_ff[i][8*ch +: 8];
         end
      end
   end

   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      rmf_median_core u_median (
         .clock   (clock),
         .advance (advance),
         .samples (chan_samples[ch]),
         .median  (chan_median[ch])
      );
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.median_red   = chan_median[0];
   assign rsp_bus.median_green = chan_median[1];
   assign rsp_bus.median_blue  = chan_median[2];
   assign rsp_bus.frame_end    = rsp_last_ff;

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && last && !csr_we) |=> (scan_row_ff == '0 && scan_col_ff == '0))
      else $error("scan position not cleared after frame end");

   a_out_row_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, out_row_ff} < len_ff))
      else $error("output row beyond column length");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("input taken while result stalled");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && !advance) |=> s4_valid_ff)
      else $error("pipeline lost a result during stall");

endmodule

FILE: design/rmf_median_core.sv
// ----------------------------------------------------------------------------
// rmf_median_core
// Three-stage rank selector: picks the middle of 25 samples of one channel.
// ----------------------------------------------------------------------------
module rmf_median_core
   import rmf_pkg::*;
(
   input  logic       clock,
   input  logic       advance,
   input  sample_type samples [WIN_CELLS],
   output sample_type median
);

   logic [WIN_CELLS-1:0] before_ff [WIN_CELLS];
   logic [WIN_CELLS-1:0] before_in [WIN_CELLS];
   sample_type           val_a_ff  [WIN_CELLS];
   sample_type           val_b_ff  [WIN_CELLS];
   logic [RANK_W-1:0]    rank_ff   [WIN_CELLS];
   logic [RANK_W-1:0]    rank_in   [WIN_CELLS];
   sample_type           median_ff;
   sample_type           median_in;

   always_comb begin
      for (int i = 0; i < WIN_CELLS; i++) begin
         for (int j = 0; j < WIN_CELLS; j++) begin
            before_in[i][j] = (samples[j] < samples[i]) ||
                              ((samples[j] == samples[i]) && (j < i));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < WIN_CELLS; i++) begin
         rank_in[i] = RANK_W'($countones(before_ff[i]));
      end
   end

   always_comb begin
      median_in = '0;
      for (int i = 0; i < WIN_CELLS; i++) begin
         if (rank_ff[i] == RANK_W'(MEDIAN_IDX)) begin
            median_in = median_in | val_b_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         before_ff <= before_in;
         val_a_ff  <= samples;
         rank_ff   <= rank_in;
         val_b_ff  <= val_a_ff;
         median_ff <= median_in;
      end
   end

   assign median = median_ff;

endmodule

FILE: dv/tb_rgb_median_filter_5x5_top.sv
// ----------------------------------------------------------------------------
// tb_rgb_median_filter_5x5_top
// Self-checking bench for the 5x5 RGB median filter. Pixel frames of many
// sizes go in through the request channel with random gaps and back-pressure.
// A behavioral window/median predictor builds the expected medians, and every
// response transaction is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_rgb_median_filter_5x5_top;
   import rmf_pkg::*;

   localparam int STORE_DEPTH = 4 * MAX_LINE + 2 * WINDOW;
   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 20;
   localparam int RAND_ITEMS  = 800;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd2;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } median_type;

   typedef struct {
      int         reps;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       flush;
      bit         typed;
      median_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CNT_W-1:0] csr_wdata;

   rmf_req_if req_bus ();
   rmf_rsp_if rsp_bus ();

   rgb_median_filter_5x5_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor state
   int unsigned col_len;
   int unsigned col_cnt;
   logic [PIX_W-1:0] pix_store [STORE_DEPTH];
   int unsigned scan_row;
   int unsigned scan_col;
   int unsigned out_cnt;
   bit frame_closed;

   median_type pending_medians[$];
   int errors;
   int items_sent;
   int results_seen;
   int frames_done;
   int idle_cycles;
   bit calm;

   function automatic logic [7:0] middle_of(input logic [7:0] v [WIN_CELLS]);
      logic [7:0] key;
      int j;
      for (int i = 1; i < WIN_CELLS; i++) begin
         key = v[i];
         j = i - 1;
         while (j >= 0 && v[j] > key) begin
            v[j+1] = v[j];
            j--;
         end
         v[j+1] = key;
      end
      return v[MEDIAN_IDX];
   endfunction

   function automatic bit filter_step(input logic [7:0] r, g, b, input logic fl,
                                      output median_type m);
      int unsigned total, n, lag, p, px, py, k;
      int cx, cy;
      logic [PIX_W-1:0] val;
      logic [7:0] rv [WIN_CELLS];
      logic [7:0] gv [WIN_CELLS];
      logic [7:0] bv [WIN_CELLS];
      total = col_cnt * col_len;
      n = scan_col * col_len + scan_row;
      lag = HALF_WIN * col_len + HALF_WIN;
      m = '0;
      if (n < total)
         pix_store[n % STORE_DEPTH] = fl ? '0 : {b, g, r};
      scan_row++;
      if (scan_row >= col_len) begin
         scan_row = 0;
         scan_col++;
      end
      if (n < lag)
         return 1'b0;
      p = out_cnt;
      px = p / col_len;
      py = p % col_len;
      k = 0;
      for (int dy = -HALF_WIN; dy <= HALF_WIN; dy++) begin
         for (int dx = -HALF_WIN; dx <= HALF_WIN; dx++) begin
            cx = int'(px) + dx;
            cy = int'(py) + dy;
            val = '0;
            if (cx >= 0 && cy >= 0 && cx < int'(col_cnt) && cy < int'(col_len))
               val = pix_store[(cx * col_len + cy) % STORE_DEPTH];
            rv[k] = val[7:0];
            gv[k] = val[15:8];
            bv[k] = val[23:16];
            k++;
         end
      end
      m.red = middle_of(rv);
      m.green = middle_of(gv);
      m.blue = middle_of(bv);
      m.frame_end = (p + 1 >= total);
      out_cnt++;
      if (m.frame_end) begin
         scan_row = 0;
         scan_col = 0;
         out_cnt = 0;
         frame_closed = 1'b1;
         frames_done++;
      end
      return 1'b1;
   endfunction

   task automatic send_pixel(input logic [7:0] r, g, b, input logic fl,
                             input bit typed = 1'b0, input median_type want = '0);
      median_type m;
      while (!calm && $urandom_range(99) < 6) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.red <= r;
      req_bus.green <= g;
      req_bus.blue <= b;
      req_bus.flush <= fl;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (filter_step(r, g, b, fl, m))
         pending_medians.push_back(typed ? want : m);
   endtask

   task automatic send_random_pixel();
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                 $urandom_range(99) < 5);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_medians.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
      int unsigned v;
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_COLUMN_LENGTH) begin
         v = 32'(val & 13'h7ff);
         col_len = (v < WINDOW) ? WINDOW : (v > MAX_LINE) ? MAX_LINE : v;
      end else if (idx == CSR_COLUMN_COUNT) begin
         v = 32'(val);
         col_cnt = (v < WINDOW) ? WINDOW : (v > MAX_COLS) ? MAX_COLS : v;
      end else begin
         return;
      end
      scan_row = 0;
      scan_col = 0;
      out_cnt = 0;
   endtask

   task automatic set_frame(input logic [CNT_W-1:0] len, input logic [CNT_W-1:0] cnt);
      wait_idle();
      write_reg(CSR_COLUMN_LENGTH, len);
      write_reg(CSR_COLUMN_COUNT, cnt);
   endtask

   task automatic run_frame(input bit broken);
      int unsigned total, stop_at;
      total = col_len * col_cnt;
      stop_at = broken ? $urandom_range(total - 1, 1) : total;
      frame_closed = 1'b0;
      for (int unsigned i = 0; i < stop_at; i++)
         send_random_pixel();
      if (!broken)
         while (!frame_closed)
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   // 5x5 frame: bright block, mixed pixels, black flushes inside the frame,
   // then colored items past the frame end that only push results
   stim_row_type directed [6] = '{
      '{12, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0, '0},
      '{1,  8'hff, 8'hff, 8'hff, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
      '{6,  8'h00, 8'h80, 8'hff, 1'b0, 1'b0, '0},
      '{6,  8'h5a, 8'ha5, 8'h01, 1'b1, 1'b0, '0},
      '{11, 8'hff, 8'h7f, 8'hfe, 1'b0, 1'b0, '0},
      '{1,  8'hff, 8'hff, 8'hff, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}}
   };

   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b1;
      else
         rsp_bus.ready <= calm || ($urandom_range(99) >= 6);
   end

   always @(posedge clock) begin
      median_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.median_red, rsp_bus.median_green, rsp_bus.median_blue,
                rsp_bus.frame_end};
         results_seen++;
         if (pending_medians.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result r=%0d g=%0d b=%0d end=%0b",
                        got.red, got.green, got.blue, got.frame_end);
         end else begin
            want = pending_medians.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.frame_end !== want.frame_end) begin
               errors++;
               if (errors <= 10)
                  $display("result %0d: expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
                           results_seen, want.red, want.green, want.blue, want.frame_end,
                           got.red, got.green, got.blue, got.frame_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int start_items;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_COLUMN_LENGTH;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.red <= '0;
      req_bus.green <= '0;
      req_bus.blue <= '0;
      req_bus.flush <= 1'b0;
      errors = 0;
      items_sent = 0;
      results_seen = 0;
      frames_done = 0;
      idle_cycles = 0;
      calm = 1'b0;
      col_len = 480;
      col_cnt = 640;
      scan_row = 0;
      scan_col = 0;
      out_cnt = 0;
      foreach (pix_store[i]) pix_store[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 5; i++)
         send_random_pixel();
      wait_idle();
      write_reg(CSR_SPARE, 13'h1fff);
      write_reg(CSR_COLUMN_LENGTH, 13'd0);
      write_reg(CSR_COLUMN_COUNT, 13'd0);

      foreach (directed[i])
         for (int j = 0; j < directed[i].reps; j++)
            send_pixel(directed[i].red, directed[i].green, directed[i].blue,
                       directed[i].flush, directed[i].typed, directed[i].want);

      start_items = items_sent;
      while (items_sent - start_items < RAND_ITEMS) begin
         calm = (items_sent - start_items > 300 && items_sent - start_items < 450);
         set_frame(CNT_W'($urandom_range(12, 5)), CNT_W'($urandom_range(9, 5)));
         for (int f = $urandom_range(2, 1); f > 0; f--) begin
            if ($urandom_range(9) == 0) begin
               run_frame(1'b1);
               break;
            end
            run_frame(1'b0);
            if (frames_done == 2) begin
               req_bus.valid <= 1'b0;
               while (pending_medians.size() != 0)
                  @(posedge clock);
            end
         end
      end
      calm = 1'b0;

      req_bus.valid <= 1'b0;
      while (pending_medians.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d pixel transactions, checked %0d medians over %0d frames",
               items_sent, results_seen, frames_done);
      $display("Frame sizes ranged from 5x5 up to 12x9, with cut-short frames and stalls");
      if (errors == 0 && pending_medians.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, pending_medians.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: rgb_median_filter_5x5_top.f
design/rmf_pkg.sv
design/rmf_req_if.sv
design/rmf_rsp_if.sv
design/rmf_median_core.sv
design/rgb_median_filter_5x5_top.sv
dv/tb_rgb_median_filter_5x5_top.sv
